// ===== hw/rtl/mgf_pkg.sv =====
// Shared types and constants for the missing sample gap filler.
`default_nettype none

package mgf_pkg;

    // Default configuration
    localparam int MAX_GAP_DEF      = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths of the channels
    localparam int SAMPLE_PORT_W = 16;
    localparam int VALUE_PORT_W  = 16;
    localparam int EXT_W         = 32;

    // One input request
    typedef struct packed {
        logic [SAMPLE_PORT_W-1:0] sample;
        logic                     missing;
        logic                     frame_last;
    } sample_in_t;

    // One result request
    typedef struct packed {
        logic [VALUE_PORT_W-1:0] value;
        logic                    still_missing;
        logic                    gap_overflow;
        logic                    frame_end;
        logic                    run_last;
    } result_t;

    // Kind of result loaded into the output register
    typedef enum logic [1:0] {
        EMIT_FILL   = 2'd0,
        EMIT_SAMPLE = 2'd1,
        EMIT_OVF    = 2'd2,
        EMIT_TAIL   = 2'd3
    } emit_kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       latch;
        logic       pend_inc;
        logic       emit;
        emit_kind_t kind;
        logic       run_last;
        logic       frame_end;
        logic       clear_frame;
    } mgf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic pend_zero;
        logic pend_one;
        logic pend_full;
        logic lat_last;
    } mgf_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mgf_datapath.sv =====
// Datapath: frame state, latched request, fill arithmetic and output register.
`default_nettype none

module mgf_datapath #(
    parameter int MAX_GAP      = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  mgf_pkg::sample_in_t  s_data,
    input  wire                  m_ready,
    output logic                 m_valid,
    output mgf_pkg::result_t     m_data,
    input  mgf_pkg::mgf_cmd_t    cmd,
    output mgf_pkg::mgf_status_t status
);
    import mgf_pkg::*;

    localparam int GAP_W = $clog2(MAX_GAP + 1);
    localparam logic [GAP_W-1:0] GAP_FULL = GAP_W'(MAX_GAP);
    localparam logic [GAP_W-1:0] GAP_ONE  = GAP_W'(1);

    logic [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic                    have_left_reg, have_left_next;
    logic [GAP_W-1:0]        pend_reg, pend_next;
    logic [SAMPLE_WIDTH-1:0] smp_reg;
    logic                    last_reg;
    result_t                 out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [EXT_W-1:0]        in_ext;
    logic [SAMPLE_WIDTH-1:0] smp_in;
    logic [SAMPLE_WIDTH:0]   sum;
    logic [SAMPLE_WIDTH-1:0] fill_val;
    logic [SAMPLE_WIDTH-1:0] val_sel;
    logic                    miss_sel;
    logic [EXT_W-1:0]        val_ext;

    // Keep the low sample bits of the incoming request
    assign in_ext = EXT_W'(s_data.sample);
    assign smp_in = in_ext[SAMPLE_WIDTH-1:0];

    // Midpoint of left value and right sample, or the sample if no left value
    assign sum      = {1'b0, prev_reg} + {1'b0, smp_reg};
    assign fill_val = have_left_reg ? sum[SAMPLE_WIDTH:1] : smp_reg;

    // Select the value of the result being loaded
    always_comb begin
        val_sel  = prev_reg;
        miss_sel = 1'b0;
        case (cmd.kind)
            EMIT_FILL: begin
                val_sel = fill_val;
            end
            EMIT_SAMPLE: begin
                val_sel = smp_reg;
            end
            EMIT_OVF, EMIT_TAIL: begin
                val_sel  = prev_reg;
                miss_sel = ~have_left_reg;
            end
            default: begin
                val_sel = prev_reg;
            end
        endcase
    end

    assign val_ext = miss_sel ? '0 : EXT_W'(val_sel);

    // Update frame state
    always_comb begin
        prev_next      = prev_reg;
        have_left_next = have_left_reg;
        pend_next      = pend_reg;
        if (cmd.pend_inc) begin
            pend_next = pend_reg + GAP_ONE;
        end
        if (cmd.emit) begin
            case (cmd.kind)
                EMIT_FILL: begin
                    prev_next      = fill_val;
                    have_left_next = 1'b1;
                    pend_next      = pend_reg - GAP_ONE;
                end
                EMIT_SAMPLE: begin
                    prev_next      = smp_reg;
                    have_left_next = 1'b1;
                    pend_next      = '0;
                end
                EMIT_TAIL: begin
                    pend_next = pend_reg - GAP_ONE;
                end
                default: begin
                    pend_next = pend_reg;
                end
            endcase
        end
        if (cmd.clear_frame) begin
            prev_next      = '0;
            have_left_next = 1'b0;
            pend_next      = '0;
        end
    end

    // Load or drain the output register
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        if (cmd.emit) begin
            out_next.value         = val_ext[VALUE_PORT_W-1:0];
            out_next.still_missing = miss_sel;
            out_next.gap_overflow  = (cmd.kind == EMIT_OVF);
            out_next.frame_end     = cmd.frame_end;
            out_next.run_last      = cmd.run_last;
            out_valid_next         = 1'b1;
        end
    end

    // Control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_left_reg <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            have_left_reg <= have_left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.latch) begin
            smp_reg  <= smp_in;
            last_reg <= s_data.frame_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign status.out_free  = ~out_valid_reg | m_ready;
    assign status.pend_zero = (pend_reg == '0);
    assign status.pend_one  = (pend_reg == GAP_ONE);
    assign status.pend_full = (pend_reg == GAP_FULL);
    assign status.lat_last  = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mgf_ctrl.sv =====
// Controller: sequences fill, sample, overflow and tail results per request.
`default_nettype none

module mgf_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  in_missing,
    input  wire                  in_last,
    input  mgf_pkg::mgf_status_t status,
    output mgf_pkg::mgf_cmd_t    cmd
);
    import mgf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FILL   = 5'b00010,
        ST_SAMPLE = 5'b00100,
        ST_OVF    = 5'b01000,
        ST_TAIL   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;

    // Decide the next step and the datapath commands
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.kind        = EMIT_FILL;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    if (!in_missing) begin
                        state_next = status.pend_zero ? ST_SAMPLE : ST_FILL;
                    end else if (status.pend_full) begin
                        state_next = ST_OVF;
                    end else begin
                        cmd.pend_inc = 1'b1;
                        state_next   = in_last ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_FILL;
                    if (status.pend_one) begin
                        state_next = ST_SAMPLE;
                    end
                end
            end
            ST_SAMPLE: begin
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.kind        = EMIT_SAMPLE;
                    cmd.run_last    = 1'b1;
                    cmd.frame_end   = status.lat_last;
                    cmd.clear_frame = status.lat_last;
                    state_next      = ST_IDLE;
                end
            end
            ST_OVF: begin
                // The full gap follows the flushed sample on a frame end
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = EMIT_OVF;
                    cmd.run_last = ~status.lat_last;
                    state_next   = status.lat_last ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_TAIL;
                    if (status.pend_one) begin
                        cmd.run_last    = 1'b1;
                        cmd.frame_end   = 1'b1;
                        cmd.clear_frame = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/missing_sample_gap_filler.sv =====
// Top level of the missing sample gap filler: controller plus datapath.
//
//  channel | ports                    | moves
//  --------+--------------------------+-------------------------------------
//  input   | s_valid s_ready s_data   | one sample request (sample, flags)
//  result  | m_valid m_ready m_data   | one cleaned sample request
//
// A request that yields no result ends when accepted. A request that
// yields n results is accepted first, then passes them one result per
// cycle through the single output register while the result side is ready.
// Input is taken only between requests; the output register lets the last
// result wait while the next request is accepted. Reset is synchronous,
// active low, and clears the frame state; there is no clearing pass.
`default_nettype none

module missing_sample_gap_filler #(
    parameter int MAX_GAP      = mgf_pkg::MAX_GAP_DEF,
    parameter int SAMPLE_WIDTH = mgf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  mgf_pkg::sample_in_t s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output mgf_pkg::result_t    m_data
);
    import mgf_pkg::*;

    mgf_cmd_t    cmd;
    mgf_status_t status;

    mgf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .in_missing (s_data.missing),
        .in_last    (s_data.frame_last),
        .status     (status),
        .cmd        (cmd)
    );

    mgf_datapath #(
        .MAX_GAP      (MAX_GAP),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

// ===== tb/missing_sample_gap_filler_tb.sv =====
// Self-checking testbench for the missing sample gap filler.
`timescale 1ns / 1ps

module missing_sample_gap_filler_tb;
    import mgf_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int GAP_LIMIT    = MAX_GAP_DEF;
    localparam int TOTAL_ITEMS  = 220;
    localparam int IDLE_PCT     = 19;
    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_PRINTS   = 50;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    sample_in_t s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    result_t    m_data;

    // Pending sample requests and cleaned samples still owed by the block
    sample_in_t sample_q[$];
    result_t    cleaned_q[$];

    // Shadow of the frame state
    logic [15:0] fill_prev;
    logic        fill_have_left;
    logic [5:0]  fill_pending;

    int  mismatches = 0;
    int  sent_count = 0;
    int  results_seen = 0;
    bit  req_pending = 1'b0;
    int  stall_left = 0;
    bit  stall_done = 1'b0;

    missing_sample_gap_filler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic add_sample(input logic [15:0] smp, input logic miss, input logic last);
        sample_in_t req;
        req.sample     = smp;
        req.missing    = miss;
        req.frame_last = last;
        sample_q.push_back(req);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: pick_sample = 16'h0000;
            1: pick_sample = 16'hFFFF;
            default: pick_sample = 16'($urandom);
        endcase
    endfunction

    task automatic owe_cleaned(input logic [15:0] v, input logic miss, input logic ovf);
        result_t r;
        r.value         = miss ? 16'h0000 : v;
        r.still_missing = miss;
        r.gap_overflow  = ovf;
        r.frame_end     = 1'b0;
        r.run_last      = 1'b0;
        cleaned_q.push_back(r);
    endtask

    // Advance the shadow frame state by one request and queue what it yields
    task automatic fill_gaps(input sample_in_t req);
        logic [16:0] sum;
        result_t     r;
        int          n;
        int          i;
        n = 0;
        if (!req.missing) begin
            // release the held gap, each fill halfway toward the new sample
            for (i = 0; i < fill_pending; i++) begin
                if (fill_have_left) begin
                    sum = {1'b0, fill_prev} + {1'b0, req.sample};
                    fill_prev = sum[16:1];
                end else begin
                    fill_prev = req.sample;
                end
                fill_have_left = 1'b1;
                owe_cleaned(fill_prev, 1'b0, 1'b0);
                n++;
            end
            fill_pending   = '0;
            fill_prev      = req.sample;
            fill_have_left = 1'b1;
            owe_cleaned(req.sample, 1'b0, 1'b0);
            n++;
        end else begin
            // flush the oldest held sample early once the gap is full
            if (fill_pending + 1 > GAP_LIMIT) begin
                owe_cleaned(fill_prev, !fill_have_left, 1'b1);
                n++;
                fill_pending = 6'(GAP_LIMIT);
            end else begin
                fill_pending = fill_pending + 6'd1;
            end
            // copy the left value into the trailing gap
            if (req.frame_last) begin
                for (i = 0; i < fill_pending; i++) begin
                    owe_cleaned(fill_prev, !fill_have_left, 1'b0);
                    n++;
                end
                fill_pending = '0;
            end
        end
        if (n > 0) begin
            r = cleaned_q.pop_back();
            r.run_last  = 1'b1;
            r.frame_end = req.frame_last;
            cleaned_q.push_back(r);
        end
        if (req.frame_last) begin
            fill_prev      = '0;
            fill_have_left = 1'b0;
            fill_pending   = '0;
        end
    endtask

    // Build one frame from valid samples and gaps of random length
    task automatic add_frame();
        int  segs;
        int  len;
        int  s;
        int  k;
        bit  gap;
        if ($urandom_range(9) == 0) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(GAP_LIMIT, GAP_LIMIT + 4)
                                           : $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
                add_sample(pick_sample(), 1'b1, k == len - 1);
            end
        end else begin
            segs = $urandom_range(1, 5);
            for (s = 0; s < segs; s++) begin
                gap = ($urandom_range(2) == 0);
                if (gap) begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(GAP_LIMIT - 2, GAP_LIMIT + 4)
                                                   : $urandom_range(1, 4);
                end else begin
                    len = 1;
                end
                for (k = 0; k < len; k++) begin
                    add_sample(pick_sample(), gap, (s == segs - 1) && (k == len - 1));
                end
            end
        end
    endtask

    // Stimulus: directed frames, forced overflows, then random frames
    initial begin
        int k;
        int target;
        // single valid sample frames at both extremes
        add_sample(16'hFFFF, 1'b0, 1'b1);
        add_sample(16'h0000, 1'b0, 1'b1);
        // frames with no valid sample at all
        add_sample(16'hABCD, 1'b1, 1'b0);
        add_sample(16'h5432, 1'b1, 1'b1);
        add_sample(16'hFFFF, 1'b1, 1'b1);
        // leading gap copies the first valid sample
        add_sample(16'hFFFF, 1'b1, 1'b0);
        add_sample(16'h0000, 1'b1, 1'b0);
        add_sample(16'h1234, 1'b0, 1'b0);
        // midpoint fills, carry out of the sum
        add_sample(16'hFFFF, 1'b0, 1'b0);
        add_sample(16'h7777, 1'b1, 1'b0);
        add_sample(16'h0001, 1'b0, 1'b0);
        add_sample(16'h0000, 1'b1, 1'b0);
        add_sample(16'hFFFF, 1'b0, 1'b0);
        // trailing gap copies the last output
        add_sample(16'h1111, 1'b1, 1'b0);
        add_sample(16'h2222, 1'b1, 1'b1);
        // chained fills toward zero
        add_sample(16'h8000, 1'b0, 1'b0);
        add_sample(16'hFFFF, 1'b1, 1'b0);
        add_sample(16'hFFFF, 1'b1, 1'b0);
        add_sample(16'h0000, 1'b0, 1'b0);
        add_sample(16'h5555, 1'b0, 1'b1);
        // gap overflow with no left value, then resolved by a valid sample
        for (k = 0; k < GAP_LIMIT + 1; k++) begin
            add_sample(pick_sample(), 1'b1, 1'b0);
        end
        add_sample(pick_sample(), 1'b0, 1'b1);
        // gap overflow with a left value, ending the frame inside the gap
        add_sample(pick_sample(), 1'b0, 1'b0);
        for (k = 0; k < GAP_LIMIT + 2; k++) begin
            add_sample(pick_sample(), 1'b1, k == GAP_LIMIT + 1);
        end
        // top up with random frames to the total request count
        target = TOTAL_ITEMS;
        while (sample_q.size() < target) begin
            add_frame();
        end
    end

    // Reset and end of run
    initial begin
        fill_prev      = '0;
        fill_have_left = 1'b0;
        fill_pending   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (sample_q.size() != 0 || req_pending || cleaned_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && cleaned_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

    // Driver: offer the next sample request, hold it until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!req_pending) begin
            if (sample_q.size() != 0 &&
                ((sent_count >= 120 && sent_count < 180) || $urandom_range(99) >= IDLE_PCT)) begin
                s_data      <= sample_q.pop_front();
                s_valid     <= 1'b1;
                req_pending = 1'b1;
                sent_count++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!stall_done && results_seen >= 40) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (results_seen >= 100 && results_seen < 200) ||
                       ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: check each cleaned sample, then predict from any taken request
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (cleaned_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h", m_data.value));
                end else begin
                    want = cleaned_q.pop_front();
                    if (m_data.value !== want.value)
                        report_mismatch($sformatf("value got %h want %h",
                                                  m_data.value, want.value));
                    if (m_data.still_missing !== want.still_missing)
                        report_mismatch($sformatf("still_missing got %b want %b",
                                                  m_data.still_missing, want.still_missing));
                    if (m_data.gap_overflow !== want.gap_overflow)
                        report_mismatch($sformatf("gap_overflow got %b want %b",
                                                  m_data.gap_overflow, want.gap_overflow));
                    if (m_data.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %b want %b",
                                                  m_data.frame_end, want.frame_end));
                    if (m_data.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last got %b want %b",
                                                  m_data.run_last, want.run_last));
                end
            end
            if (s_valid && s_ready) begin
                fill_gaps(s_data);
                req_pending = 1'b0;
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/mgf_pkg.sv
hw/rtl/mgf_datapath.sv
hw/rtl/mgf_ctrl.sv
hw/rtl/missing_sample_gap_filler.sv
tb/missing_sample_gap_filler_tb.sv
